### hw/rtl/nrg_pkg.sv
// ----------------------------------------------------------------------------
// nrg_pkg
// shared constants, the atom record carried along the cell chain and the
// saturating gradient add
// ----------------------------------------------------------------------------
package nrg_pkg;

  localparam int MAX_ATOMS = 64;
  localparam int IDX_W     = $clog2(MAX_ATOMS);
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

  // one atom as held by a cell of the chain
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        q;
    logic signed [47:0] ax;
    logic signed [47:0] ay;
    logic signed [47:0] az;
    logic               sat;
    logic               coin;
  } atom_t;

  // pair engine result: signed terms for the first atom of the pair
  typedef struct packed {
    logic signed [47:0] vx;
    logic signed [47:0] vy;
    logic signed [47:0] vz;
    logic               sat;
    logic               coin;
  } pair_res_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic               clamped;
  } sat_res_t;

  // 48-bit add clamped to the signed range
  function automatic sat_res_t sat_add(input logic signed [47:0] a,
                                       input logic signed [47:0] b);
    logic [48:0] s;
    sat_res_t    r;
    s = {a[47], a} + {b[47], b};
    r.clamped = s[48] ^ s[47];
    if (s[48] == 1'b0 && s[47] == 1'b1) begin
      r.value = {1'b0, {47{1'b1}}};
    end else if (s[48] == 1'b1 && s[47] == 1'b0) begin
      r.value = {1'b1, {47{1'b0}}};
    end else begin
      r.value = s[47:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/nrg_cell.sv
// ----------------------------------------------------------------------------
// nrg_cell
// one link of the atom chain: holds an atom and takes its neighbour's on shift
// ----------------------------------------------------------------------------
module nrg_cell (
  input  logic          clk,
  input  logic          shift,
  input  nrg_pkg::atom_t din,
  output nrg_pkg::atom_t dout
);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

### hw/rtl/nrg_pair.sv
// ----------------------------------------------------------------------------
// nrg_pair
// sequenced pair engine: distance, normalise, root, and bit-serial division
// ----------------------------------------------------------------------------
module nrg_pair (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  nrg_pkg::atom_t    ai,
  input  nrg_pkg::atom_t    aj,
  output logic              done,
  output nrg_pkg::pair_res_t res
);

  typedef enum logic [8:0] {
    PE_IDLE = 9'b000000001,
    PE_DIFF = 9'b000000010,
    PE_SQ   = 9'b000000100,
    PE_NORM = 9'b000001000,
    PE_SQRT = 9'b000010000,
    PE_PMUL = 9'b000100000,
    PE_NMUL = 9'b001000000,
    PE_QDIV = 9'b010000000,
    PE_FRAC = 9'b100000000
  } pe_state_t;

  pe_state_t          state;
  logic [2:0][31:0]   a_r;
  logic [2:0]         neg;
  logic [2:0][46:0]   m_r;
  logic               e_r;
  logic [63:0]        s;
  logic [4:0]         t;
  logic [63:0]        sv;
  logic [63:0]        r;
  logic [63:0]        bitm;
  logic [63:0]        pp;
  logic [31:0]        qq;
  logic [63:0]        rem;
  logic [47:0]        quo;
  logic [1:0]         c;
  logic [1:0]         b;
  logic [6:0]         k;
  logic               sat_r;
  logic               coin_r;

  logic [2:0][31:0]   pi;
  logic [2:0][31:0]   pj;
  logic [2:0][32:0]   d;
  logic [2:0][32:0]   mg;
  logic               e_w;
  logic [63:0]        root_sum;
  logic [65:0]        pshift;
  logic [64:0]        rem2;

  assign pi = {ai.z, ai.y, ai.x};
  assign pj = {aj.z, aj.y, aj.x};

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      d[n]  = {pj[n][31], pj[n]} - {pi[n][31], pi[n]};
      mg[n] = d[n][32] ? (33'd0 - d[n]) : d[n];
    end
    e_w      = |{mg[0][32:31], mg[1][32:31], mg[2][32:31]};
    root_sum = r + bitm;
    pshift   = {2'b00, pp} << b;
    rem2     = {rem, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PE_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        PE_IDLE: begin
          if (start) begin
            state <= PE_DIFF;
          end
        end
        PE_DIFF: begin
          for (int n = 0; n < 3; n++) begin
            a_r[n] <= e_w ? mg[n][32:1] : mg[n][31:0];
            neg[n] <= d[n][32];
          end
          e_r    <= e_w;
          s      <= '0;
          t      <= '0;
          c      <= '0;
          sat_r  <= 1'b0;
          coin_r <= 1'b0;
          m_r    <= '0;
          state  <= PE_SQ;
        end
        PE_SQ: begin
          s <= s + a_r[c] * a_r[c];
          c <= c + 2'd1;
          if (c == 2'd2) begin
            state <= PE_NORM;
          end
        end
        PE_NORM: begin
          if (s == 64'd0) begin
            coin_r <= 1'b1;
            done   <= 1'b1;
            state  <= PE_IDLE;
          end else if (s[63:62] == 2'b00) begin
            s <= s << 2;
            t <= t + 5'd1;
          end else begin
            sv    <= s;
            r     <= '0;
            bitm  <= 64'd1 << 62;
            state <= PE_SQRT;
          end
        end
        PE_SQRT: begin
          if (bitm == 64'd0) begin
            state <= PE_PMUL;
          end else begin
            if (sv >= root_sum) begin
              sv <= sv - root_sum;
              r  <= (r >> 1) + bitm;
            end else begin
              r <= r >> 1;
            end
            bitm <= bitm >> 2;
          end
        end
        PE_PMUL: begin
          pp    <= s[63:32] * r[31:0];
          qq    <= ai.q * aj.q;
          c     <= '0;
          state <= PE_NMUL;
        end
        PE_NMUL: begin
          rem   <= qq * a_r[c];
          quo   <= '0;
          b     <= 2'd2;
          state <= PE_QDIV;
        end
        PE_QDIV: begin
          // integer part of the quotient is below eight
          if ({2'b00, rem} >= pshift) begin
            rem    <= rem - pshift[63:0];
            quo[b] <= 1'b1;
          end
          b <= b - 2'd1;
          if (b == 2'd0) begin
            k     <= 7'd20 + {2'b00, t} + {1'b0, t, 1'b0} - {5'b00000, e_r, 1'b0};
            state <= PE_FRAC;
          end
        end
        PE_FRAC: begin
          if (k == 7'd0 || quo[47]) begin
            m_r[c] <= quo[47] ? {47{1'b1}} : quo[46:0];
            if (quo[47]) begin
              sat_r <= 1'b1;
            end
            c <= c + 2'd1;
            if (c == 2'd2) begin
              done  <= 1'b1;
              state <= PE_IDLE;
            end else begin
              state <= PE_NMUL;
            end
          end else begin
            if (rem2 >= {1'b0, pp}) begin
              rem <= 64'(rem2 - {1'b0, pp});
              quo <= {quo[46:0], 1'b1};
            end else begin
              rem <= rem2[63:0];
              quo <= {quo[46:0], 1'b0};
            end
            k <= k - 7'd1;
          end
        end
        default: state <= PE_IDLE;
      endcase
    end
  end

  assign res.vx   = neg[0] ? (48'd0 - {1'b0, m_r[0]}) : {1'b0, m_r[0]};
  assign res.vy   = neg[1] ? (48'd0 - {1'b0, m_r[1]}) : {1'b0, m_r[1]};
  assign res.vz   = neg[2] ? (48'd0 - {1'b0, m_r[2]}) : {1'b0, m_r[2]};
  assign res.sat  = sat_r;
  assign res.coin = coin_r;

  assert property (@(posedge clk) disable iff (rst)
    done |-> state == PE_IDLE)
    else $error("pair result raised while engine busy");

  assert property (@(posedge clk) disable iff (rst)
    (state == PE_SQRT) |-> (s[63:62] != 2'b00))
    else $error("root taken of an unnormalised sum");

  assert property (@(posedge clk) disable iff (rst)
    (state == PE_FRAC) |-> (pp[63:61] != 3'b000))
    else $error("divisor below normalised range");

endmodule

### hw/rtl/nuclear_repulsion_gradient_unit.sv
// ----------------------------------------------------------------------------
// nuclear_repulsion_gradient_unit
// pairwise coulomb gradient of up to MAX_ATOMS point charges on a cell chain
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                               | side band
// s       | in  | pos_x[31:0] pos_y[63:32] pos_z[95:64] chg[111:96] | tlast = final_atom
// m       | out | grad_x grad_y grad_z (48 each), atom_index[149:144]| tlast = last_result,
//         |     |                                                  | tuser = saturated, coincident
//
// atoms enter one per cycle while loading; the final atom starts the sweep
// each pivot makes one lap of the chain (MAX_ATOMS + 1 shifts) plus one pair
// evaluation per later atom; the time a pair takes is set by the root and the
// bit-serial divider of the shared pair engine; a coincident pair skips both
// results leave one per cycle from the output register while the output is not stalled, in load order
// reset is synchronous and clears control only; the chain needs no clearing
// a stalled output holds the chain; no input is taken until the last result
// has moved into the output register
// ----------------------------------------------------------------------------
module nuclear_repulsion_gradient_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [111:0]   s_tdata,   // pos_x, pos_y, pos_z, charge
  input  logic           s_tlast,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [151:0]   m_tdata,   // grad_x, grad_y, grad_z, atom_index, zero pad
  output logic           m_tlast,
  output logic [1:0]     m_tuser    // saturated, coincident
);

  localparam int MAX   = nrg_pkg::MAX_ATOMS;
  localparam int IDX_W = nrg_pkg::IDX_W;
  localparam int CNT_W = nrg_pkg::CNT_W;

  // sequencer states
  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_ALIGN = 6'b000010,
    S_PIVOT = 6'b000100,
    S_SCAN  = 6'b001000,
    S_PAIR  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;       // atoms in the set
  logic [IDX_W-1:0]   head_idx;  // atom index sitting in the head cell
  logic [CNT_W-1:0]   i_r;       // pivot
  logic [CNT_W-1:0]   p_r;       // shifts into the current lap
  logic [CNT_W-1:0]   k_r;       // results sent
  logic               to_out;    // alignment leads to the output phase
  nrg_pkg::atom_t     pivot;

  nrg_pkg::atom_t     ring [MAX];
  nrg_pkg::atom_t     head;
  nrg_pkg::atom_t     tail_in;
  nrg_pkg::atom_t     new_atom;
  nrg_pkg::atom_t     head_upd;
  nrg_pkg::atom_t     pivot_upd;

  logic               accept_in;
  logic               load_shift;
  logic               rot;
  logic               wb;
  logic               emit;
  logic               pair_start;
  logic               pr_done;
  nrg_pkg::pair_res_t pr_res;
  logic [CNT_W:0]     jfull;
  logic               last_pass;

  nrg_pkg::sat_res_t  pi_x, pi_y, pi_z, hj_x, hj_y, hj_z;

  // ---- chain of cells, head at cell 0, data moves towards it ----
  for (genvar g = 0; g < MAX; g++) begin : g_chain
    if (g == MAX - 1) begin : g_tail
      nrg_cell u_cell (.clk(clk), .shift(load_shift | rot), .din(tail_in), .dout(ring[g]));
    end else begin : g_body
      nrg_cell u_cell (.clk(clk), .shift(load_shift | rot), .din(ring[g+1]), .dout(ring[g]));
    end
  end

  assign head = ring[0];

  nrg_pair u_pair (
    .clk   (clk),
    .rst   (rst),
    .start (pair_start),
    .ai    (pivot),
    .aj    (head),
    .done  (pr_done),
    .res   (pr_res)
  );

  // ---- incoming atom, gradient and flags start cleared ----
  always_comb begin
    new_atom      = '0;
    new_atom.x    = s_tdata[31:0];
    new_atom.y    = s_tdata[63:32];
    new_atom.z    = s_tdata[95:64];
    new_atom.q    = s_tdata[111:96];
  end

  // ---- pair term into the pivot (+v) and the head atom (-v) ----
  always_comb begin
    pi_x = nrg_pkg::sat_add(pivot.ax, pr_res.vx);
    pi_y = nrg_pkg::sat_add(pivot.ay, pr_res.vy);
    pi_z = nrg_pkg::sat_add(pivot.az, pr_res.vz);
    hj_x = nrg_pkg::sat_add(head.ax, 48'd0 - pr_res.vx);
    hj_y = nrg_pkg::sat_add(head.ay, 48'd0 - pr_res.vy);
    hj_z = nrg_pkg::sat_add(head.az, 48'd0 - pr_res.vz);

    pivot_upd = pivot;
    head_upd  = head;
    if (!pr_res.coin) begin
      pivot_upd.ax = pi_x.value;
      pivot_upd.ay = pi_y.value;
      pivot_upd.az = pi_z.value;
      head_upd.ax  = hj_x.value;
      head_upd.ay  = hj_y.value;
      head_upd.az  = hj_z.value;
      pivot_upd.sat = pivot.sat | pr_res.sat | pi_x.clamped | pi_y.clamped | pi_z.clamped;
      head_upd.sat  = head.sat | pr_res.sat | hj_x.clamped | hj_y.clamped | hj_z.clamped;
    end
    pivot_upd.coin = pivot.coin | pr_res.coin;
    head_upd.coin  = head.coin | pr_res.coin;
  end

  // ---- sequencer ----
  assign s_tready   = (state == S_LOAD);
  assign accept_in  = s_tvalid & s_tready;
  assign load_shift = accept_in & (cnt < CNT_W'(MAX));
  assign jfull      = {1'b0, i_r} + {1'b0, p_r};
  assign last_pass  = (i_r + 1'b1) == cnt;

  always_comb begin
    state_next = state;
    rot        = 1'b0;
    wb         = 1'b0;
    emit       = 1'b0;
    pair_start = 1'b0;
    case (state)
      S_LOAD: begin
        if (accept_in && s_tlast) begin
          state_next = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (head_idx == '0) begin
          state_next = to_out ? S_OUT : S_PIVOT;
        end else begin
          rot = 1'b1;
        end
      end
      S_PIVOT: begin
        rot        = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (p_r == CNT_W'(MAX)) begin
          // lap done: pivot goes back into its own cell
          rot        = 1'b1;
          wb         = 1'b1;
          state_next = last_pass ? S_ALIGN : S_PIVOT;
        end else if (jfull < {1'b0, cnt}) begin
          pair_start = 1'b1;
          state_next = S_PAIR;
        end else begin
          rot = 1'b1;
        end
      end
      S_PAIR: begin
        if (pr_done) begin
          rot        = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          emit = 1'b1;
          rot  = 1'b1;
          if ((k_r + 1'b1) == cnt) begin
            state_next = S_LOAD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    if (load_shift) begin
      tail_in = new_atom;
    end else if (wb) begin
      tail_in = pivot;
    end else if (state == S_PAIR) begin
      tail_in = head_upd;
    end else begin
      tail_in = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      cnt      <= '0;
      head_idx <= '0;
      i_r      <= '0;
      p_r      <= '0;
      k_r      <= '0;
      to_out   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (load_shift) begin
        cnt      <= cnt + 1'b1;
        head_idx <= IDX_W'(cnt) + 1'b1;
      end else if (rot) begin
        head_idx <= head_idx + 1'b1;
      end

      if (accept_in && s_tlast) begin
        to_out <= 1'b0;
        i_r    <= '0;
      end

      if (state == S_PIVOT) begin
        p_r <= CNT_W'(1);
      end else if (wb) begin
        i_r <= i_r + 1'b1;
        if (last_pass) begin
          to_out <= 1'b1;
          k_r    <= '0;
        end
      end else if (state == S_SCAN && rot) begin
        p_r <= p_r + 1'b1;
      end else if (state == S_PAIR && pr_done) begin
        p_r <= p_r + 1'b1;
      end

      if (emit) begin
        k_r      <= k_r + 1'b1;
        m_tvalid <= 1'b1;
        if ((k_r + 1'b1) == cnt) begin
          cnt <= '0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // pivot register follows its own lap
  always_ff @(posedge clk) begin
    if (state == S_PIVOT) begin
      pivot <= head;
    end else if (state == S_PAIR && pr_done) begin
      pivot <= pivot_upd;
    end
  end

  // output register, payload only
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {2'b00, 6'(k_r), head.az, head.ay, head.ax};
      m_tlast <= (k_r + 1'b1) == cnt;
      m_tuser <= {head.coin, head.sat};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX))
    else $error("atom count past chain length");

  assert property (@(posedge clk) disable iff (rst)
    pr_done |-> state == S_PAIR)
    else $error("pair result outside pair wait");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (k_r < cnt))
    else $error("output index past set size");

  assert property (@(posedge clk) disable iff (rst)
    pair_start |-> (jfull > {1'b0, i_r}))
    else $error("pair issued with pivot against itself");

endmodule
